### hw/rtl/swmt_pkg.sv
package swmt_pkg;

    localparam int MAX_ENTRIES_DEF  = 16;
    localparam int MINUTES_PER_HOUR = 60;
    localparam int END_SOON_LIMIT   = 10;
    localparam int MINUTES_W        = 11;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_MARK   = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [4:0] end_hour;
        logic [5:0] end_minute;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [3:0] target_entry;
    } t_in;

    typedef struct packed {
        logic       hit;
        logic [3:0] found_entry;
        logic       ending_soon;
        logic       table_full;
        logic [4:0] entry_count;
    } t_out;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
    } t_time;

    // one table row: window bounds plus its two marks
    typedef struct packed {
        t_time start_time;
        t_time end_time;
        logic  done;
        logic  soon;
    } t_entry;

    // at most 31 * 60 + 63, fits 11 bits
    function automatic logic [MINUTES_W-1:0] to_minutes(input t_time t);
        return MINUTES_W'(t.hour) * MINUTES_W'(MINUTES_PER_HOUR) + MINUTES_W'(t.minute);
    endfunction

endpackage

### hw/rtl/schedule_window_match_table.sv
// channel  | dir | valid   | stall   | payload
// -------- | --- | ------- | ------- | ---------------------
// request  | in  | i_valid | o_stall | i_data  (swmt_pkg::t_in)
// result   | out | o_valid | i_stall | o_data  (swmt_pkg::t_out)
//
// One item at a time. Add, unused opcode, mark beyond the count: idle, emit. Mark done:
// idle, mark, emit. Lookup: idle, scan over k entries (1..MAX_ENTRIES, 0 on an empty
// table), emit; the single read port of the table RAM visits one entry per cycle.
// A new beat is taken while the previous result still sits in the output register;
// a stalled output only holds the block once the next result is ready.
// Reset (i_rst_n low, synchronous) empties the table; RAM contents are not cleared.
module schedule_window_match_table #(
    parameter int MAX_ENTRIES = swmt_pkg::MAX_ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  swmt_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output swmt_pkg::t_out  o_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int MW = swmt_pkg::MINUTES_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MARK = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx,   n_idx;
    logic [MW-1:0]   r_now,   n_now;
    swmt_pkg::t_out  r_res,   n_res;
    swmt_pkg::t_out  r_out;
    logic            r_out_valid;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    swmt_pkg::t_entry ram_wdata;
    logic [$bits(swmt_pkg::t_entry)-1:0] ram_rdata;
    swmt_pkg::t_entry rd;

    logic [MW-1:0]   start_m;
    logic [MW-1:0]   end_m;
    logic            in_win;
    logic            near_end;
    logic            set_soon;
    logic            last_entry;
    logic            load_out;

    swmt_ram #(
        .WIDTH ($bits(swmt_pkg::t_entry)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd         = swmt_pkg::t_entry'(ram_rdata);
    assign start_m    = swmt_pkg::to_minutes(rd.start_time);
    assign end_m      = swmt_pkg::to_minutes(rd.end_time);
    assign in_win     = (r_now >= start_m) && (end_m > r_now);
    assign near_end   = (end_m - r_now) <= MW'(swmt_pkg::END_SOON_LIMIT);
    assign set_soon   = near_end && !rd.done;
    assign last_entry = (32'(r_idx) + 32'd1) == 32'(r_count);
    assign load_out   = (r_state == S_EMIT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_now     = r_now;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = rd;
        ram_raddr = r_idx + AW'(1);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res   = '0;
                    n_state = S_EMIT;
                    case (i_data.opcode)
                        swmt_pkg::OP_ADD: begin
                            if (32'(r_count) >= MAX_ENTRIES) begin
                                n_res.table_full = 1'b1;
                            end else begin
                                ram_we                     = 1'b1;
                                ram_waddr                  = AW'(r_count);
                                ram_wdata.start_time.hour   = i_data.start_hour;
                                ram_wdata.start_time.minute = i_data.start_minute;
                                ram_wdata.end_time.hour     = i_data.end_hour;
                                ram_wdata.end_time.minute   = i_data.end_minute;
                                ram_wdata.done             = 1'b0;
                                ram_wdata.soon             = 1'b0;
                                n_count                    = r_count + CW'(1);
                            end
                        end
                        swmt_pkg::OP_LOOKUP: begin
                            n_now     = swmt_pkg::to_minutes({i_data.now_hour,
                                                              i_data.now_minute});
                            n_idx     = '0;
                            ram_raddr = '0;
                            if (r_count != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        swmt_pkg::OP_MARK: begin
                            if (32'(i_data.target_entry) < 32'(r_count)) begin
                                ram_raddr = AW'(i_data.target_entry);
                                n_idx     = AW'(i_data.target_entry);
                                n_state   = S_MARK;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_res.entry_count = 5'(n_count);
                end
            end
            S_SCAN: begin
                if (in_win) begin
                    if (set_soon) begin
                        ram_we         = 1'b1;
                        ram_wdata.soon = 1'b1;
                    end
                    n_res.hit         = 1'b1;
                    n_res.found_entry = 4'(r_idx);
                    n_res.ending_soon = rd.soon | set_soon;
                    n_state           = S_EMIT;
                end else if (last_entry) begin
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_MARK: begin
                // read-modify-write of the target row, end-soon mark untouched
                ram_we         = 1'b1;
                ram_wdata.done = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_now <= n_now;
        r_res <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

### hw/rtl/swmt_ram.sv
module swmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/swmt_checker.sv
module swmt_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            o_stall,
    input  logic            o_valid,
    input  logic            i_stall,
    input  swmt_pkg::t_out  o_data
);

    // one item in flight: an accepted beat closes the input until its result is out
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted back to back");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("reset left the block busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.hit) |-> (o_data.found_entry == 4'd0 && !o_data.ending_soon))
        else $error("miss carries lookup fields");

    a_hit_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.hit) |-> !o_data.table_full)
        else $error("hit and full together");

endmodule

bind schedule_window_match_table swmt_checker u_swmt_checker (.*);

### tb/schedule_window_match_table_tb.sv
`timescale 1ns / 100ps

module schedule_window_match_table_tb;

    localparam int TABLE_DEPTH  = swmt_pkg::MAX_ENTRIES_DEF;
    localparam int DAY_MINUTES  = 24 * swmt_pkg::MINUTES_PER_HOUR;
    localparam int CYCLE_LIMIT  = 300_000;
    localparam int PHASE_ITEMS  = 120;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [1:0] OP_NONE = 2'd3;   // unassigned opcode, table untouched

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    swmt_pkg::t_in  req_beat  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    swmt_pkg::t_out rsp_beat;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int cycle_count        = 0;
    int error_count        = 0;

    // predicted table contents
    swmt_pkg::t_time model_start [TABLE_DEPTH];
    swmt_pkg::t_time model_end   [TABLE_DEPTH];
    logic  model_done  [TABLE_DEPTH] = '{default: 1'b0};
    logic  model_soon  [TABLE_DEPTH] = '{default: 1'b0};
    int    model_count = 0;

    swmt_pkg::t_out expected_results [$];
    swmt_pkg::t_out next_expected;

    schedule_window_match_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_valid),
        .o_stall (req_stall),
        .i_data  (req_beat),
        .o_valid (rsp_valid),
        .i_stall (rsp_stall),
        .o_data  (rsp_beat)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int minutes_of(input swmt_pkg::t_time t);
        return int'(t.hour) * swmt_pkg::MINUTES_PER_HOUR + int'(t.minute);
    endfunction

    function automatic swmt_pkg::t_time hhmm(input int h, input int m);
        return {5'(h), 6'(m)};
    endfunction

    function automatic swmt_pkg::t_time to_hhmm(input int m);
        return hhmm(m / swmt_pkg::MINUTES_PER_HOUR, m % swmt_pkg::MINUTES_PER_HOUR);
    endfunction

    // updates the predicted table and returns the result the beat must produce
    function automatic swmt_pkg::t_out apply_schedule_item(input swmt_pkg::t_in item);
        swmt_pkg::t_out  r;
        swmt_pkg::t_time now_t;
        int    since;
        int    left;
        r = '0;
        case (item.opcode)
            swmt_pkg::OP_ADD: begin
                if (model_count >= TABLE_DEPTH) begin
                    r.table_full = 1'b1;
                end else begin
                    model_start[model_count] = {item.start_hour, item.start_minute};
                    model_end[model_count]   = {item.end_hour, item.end_minute};
                    model_done[model_count]  = 1'b0;
                    model_soon[model_count]  = 1'b0;
                    model_count++;
                end
            end
            swmt_pkg::OP_LOOKUP: begin
                now_t = {item.now_hour, item.now_minute};
                for (int i = 0; i < model_count && !r.hit; i++) begin
                    since = minutes_of(now_t) - minutes_of(model_start[i]);
                    left  = minutes_of(model_end[i]) - minutes_of(now_t);
                    if (since >= 0 && left > 0) begin
                        if (left <= swmt_pkg::END_SOON_LIMIT && !model_done[i])
                            model_soon[i] = 1'b1;
                        r.hit         = 1'b1;
                        r.found_entry = 4'(i);
                        r.ending_soon = model_soon[i];
                    end
                end
            end
            swmt_pkg::OP_MARK: begin
                if (int'(item.target_entry) < model_count)
                    model_done[item.target_entry] = 1'b1;
            end
            default: ;
        endcase
        r.entry_count = 5'(model_count);
        return r;
    endfunction

    // unused fields carry random bits
    function automatic swmt_pkg::t_in random_bits();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(swmt_pkg::t_in)-1:0];
    endfunction

    function automatic swmt_pkg::t_in add_item(input swmt_pkg::t_time s,
                                               input swmt_pkg::t_time e);
        swmt_pkg::t_in item;
        item = random_bits();
        item.opcode = swmt_pkg::OP_ADD;
        {item.start_hour, item.start_minute} = s;
        {item.end_hour, item.end_minute}     = e;
        return item;
    endfunction

    function automatic swmt_pkg::t_in lookup_item(input swmt_pkg::t_time n);
        swmt_pkg::t_in item;
        item = random_bits();
        item.opcode = swmt_pkg::OP_LOOKUP;
        {item.now_hour, item.now_minute} = n;
        return item;
    endfunction

    function automatic swmt_pkg::t_in mark_item(input logic [3:0] entry);
        swmt_pkg::t_in item;
        item = random_bits();
        item.opcode       = swmt_pkg::OP_MARK;
        item.target_entry = entry;
        return item;
    endfunction

    function automatic swmt_pkg::t_in random_window();
        int start_min;
        int end_min;
        start_min = $urandom_range(DAY_MINUTES - 1);
        if ($urandom_range(9) < 8)
            end_min = start_min + $urandom_range(1, 90);
        else
            end_min = start_min - $urandom_range(0, 60);   // never opens
        if (end_min < 0)
            end_min = 0;
        return add_item(to_hhmm(start_min), to_hhmm(end_min));
    endfunction

    function automatic swmt_pkg::t_in random_schedule_item();
        swmt_pkg::t_in item;
        int  pick;
        int  entry;
        int  probe;
        pick = $urandom_range(99);
        item = random_bits();
        if (pick < 4) begin
            return item;
        end else if (pick < 8) begin
            return random_window();
        end else if (pick < 92) begin
            item.opcode = swmt_pkg::OP_LOOKUP;
            // mostly aim at the start or the last minutes of a stored window
            if (model_count > 0 && $urandom_range(9) < 7) begin
                entry = $urandom_range(model_count - 1);
                if ($urandom_range(3) == 0)
                    probe = minutes_of(model_start[entry]) + $urandom_range(0, 1);
                else
                    probe = minutes_of(model_end[entry]) - $urandom_range(0, 12);
                if (probe >= 0 && probe < 32 * swmt_pkg::MINUTES_PER_HOUR)
                    {item.now_hour, item.now_minute} = to_hhmm(probe);
            end
            return item;
        end else if (pick < 95) begin
            item.opcode = swmt_pkg::OP_MARK;
            return item;
        end
        item.opcode = OP_NONE;
        return item;
    endfunction

    task automatic send_item(input swmt_pkg::t_in item);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_beat  <= item;
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        expected_results.push_back(apply_schedule_item(item));
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        send_item(lookup_item(hhmm(0, 0)));
        send_item(mark_item(4'd15));
        send_item({OP_NONE, {($bits(swmt_pkg::t_in) - 2){1'b1}}});
        wait_for_results();
    endtask

    task automatic test_window_lookups();
        send_item(add_item(hhmm(0, 0), hhmm(0, 5)));
        send_item(add_item(hhmm(31, 63), hhmm(0, 0)));     // never opens, out of range
        send_item(add_item(hhmm(10, 0), hhmm(10, 30)));
        send_item(add_item(hhmm(10, 20), hhmm(10, 40)));   // overlaps the one before
        send_item(add_item(hhmm(23, 59), hhmm(31, 63)));
        send_item(lookup_item(hhmm(0, 0)));                // five left: end-soon
        send_item(lookup_item(hhmm(0, 5)));                // end is exclusive: miss
        send_item(lookup_item(hhmm(10, 19)));              // eleven left
        send_item(lookup_item(hhmm(10, 20)));              // ten left, first match wins
        send_item(mark_item(4'd2));
        send_item(lookup_item(hhmm(10, 25)));              // done keeps end-soon
        send_item(mark_item(4'd3));
        send_item(lookup_item(hhmm(10, 35)));              // done blocks end-soon
        send_item(lookup_item(hhmm(31, 63)));
        send_item(lookup_item(hhmm(9, 59)));
        send_item(mark_item(4'd9));                        // beyond stored count
        send_item({OP_NONE, {($bits(swmt_pkg::t_in) - 2){1'b0}}});
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (PHASE_ITEMS) send_item(random_schedule_item());
        wait_for_results();
    endtask

    task automatic test_full_table();
        while (model_count < TABLE_DEPTH) send_item(random_window());
        repeat (3) send_item(random_window());
        repeat (12) send_item(random_schedule_item());
        send_item(mark_item(4'd15));
        send_item(lookup_item(model_end[TABLE_DEPTH-1]));
        wait_for_results();
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // result beats against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: %p", rsp_beat);
                error_count++;
            end else begin
                next_expected = expected_results.pop_front();
                compare_field("hit", next_expected.hit, rsp_beat.hit);
                compare_field("found_entry", next_expected.found_entry, rsp_beat.found_entry);
                compare_field("ending_soon", next_expected.ending_soon, rsp_beat.ending_soon);
                compare_field("table_full", next_expected.table_full, rsp_beat.table_full);
                compare_field("entry_count", next_expected.entry_count, rsp_beat.entry_count);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_window_lookups();
        test_random_traffic(0, 0);
        test_random_traffic(84, 0);
        test_random_traffic(0, 84);
        test_random_traffic(33, 33);
        test_full_table();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
